// ===== rtl/core/iepsr_pkg.sv =====
// Package for the pulse-width symbol receiver: field widths, register indexes,
// symbol codes and reset values of the configuration registers.
// No dependencies.
package iepsr_pkg;

    // Default sizes of the pulse and free-time counters.
    localparam int WIDTH_BITS_DEF = 10;
    localparam int FREE_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int CFG_W       = 10;
    localparam int FREE_IV_W   = 16;
    localparam int KIND_W      = 3;
    localparam int PW_W        = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Largest pulse width that can be reported.
    localparam logic [PW_W-1:0] PW_MAX = {PW_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0]     DEF_BIT_ZERO_WIDTH  = CFG_W'(34);
    localparam logic [CFG_W-1:0]     DEF_BIT_ONE_WIDTH   = CFG_W'(20);
    localparam logic [CFG_W-1:0]     DEF_BIT_TOLERANCE   = CFG_W'(7);
    localparam logic [CFG_W-1:0]     DEF_START_WIDTH     = CFG_W'(170);
    localparam logic [CFG_W-1:0]     DEF_START_TOLERANCE = CFG_W'(115);
    localparam logic [CFG_W-1:0]     DEF_PULSE_TIMEOUT   = CFG_W'(190);
    localparam logic [FREE_IV_W-1:0] DEF_FREE_INTERVAL   = FREE_IV_W'(500);

    // Symbol codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_ZERO    = 3'd0,
        KIND_ONE     = 3'd1,
        KIND_START   = 3'd2,
        KIND_BAD     = 3'd3,
        KIND_TIMEOUT = 3'd4
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_ZERO_WIDTH  = 3'd0,
        REG_BIT_ONE_WIDTH   = 3'd1,
        REG_BIT_TOLERANCE   = 3'd2,
        REG_START_WIDTH     = 3'd3,
        REG_START_TOLERANCE = 3'd4,
        REG_PULSE_TIMEOUT   = 3'd5,
        REG_FREE_INTERVAL   = 3'd6
    } t_cfg_idx;

endpackage

// ===== rtl/core/iepsr_ifs.sv =====
// Valid/ready channel interfaces of the pulse-width symbol receiver:
// line samples in, symbols out, and the configuration write channel.
// Depends on iepsr_pkg.
interface iepsr_sample_if;
    logic valid;
    logic ready;
    logic bus_level;

    modport source (output valid, output bus_level, input ready);
    modport sink   (input valid, input bus_level, output ready);
endinterface

interface iepsr_symbol_if;
    import iepsr_pkg::*;
    logic              valid;
    logic              ready;
    logic              symbol_valid;
    logic [KIND_W-1:0] symbol_kind;
    logic [PW_W-1:0]   pulse_width;
    logic              bus_free;

    modport source (output valid, output symbol_valid, output symbol_kind,
                    output pulse_width, output bus_free, input ready);
    modport sink   (input valid, input symbol_valid, input symbol_kind,
                    input pulse_width, input bus_free, output ready);
endinterface

interface iepsr_cfg_if;
    import iepsr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/iepsr_core.sv =====
// Channel     Dir  Payload                                          Accept
// i_sample    in   bus_level                                        valid & ready
// o_symbol    out  symbol_valid, symbol_kind, pulse_width, bus_free valid & ready
// i_cfg       in   index, data                                      valid & ready
//
// Every line sample yields one result in the cycle after it is accepted; a sample
// can be accepted in every cycle. The pulse state is updated at the accepting
// edge and the result lands in a single output register. While that register
// holds an untaken result, a new sample is accepted only in a cycle in which
// the result is taken. Synchronous active-low reset restores the register
// defaults and clears the pulse state; the configuration port is always ready.
// Depends on iepsr_pkg and iepsr_ifs.
module iepsr_core #(
    parameter int WIDTH_BITS = iepsr_pkg::WIDTH_BITS_DEF,
    parameter int FREE_BITS  = iepsr_pkg::FREE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    iepsr_sample_if.sink    i_sample,
    iepsr_symbol_if.source  o_symbol,
    iepsr_cfg_if.sink       i_cfg
);
    import iepsr_pkg::*;

    // Comparison widths that cover both the counters and the registers.
    localparam int HW = (WIDTH_BITS > CFG_W) ? WIDTH_BITS : CFG_W;
    localparam int FW = (FREE_BITS > FREE_IV_W) ? FREE_BITS : FREE_IV_W;

    // Configuration registers.
    logic [CFG_W-1:0]     r_bit_zero_width;
    logic [CFG_W-1:0]     r_bit_one_width;
    logic [CFG_W-1:0]     r_bit_tolerance;
    logic [CFG_W-1:0]     r_start_width;
    logic [CFG_W-1:0]     r_start_tolerance;
    logic [CFG_W-1:0]     r_pulse_timeout;
    logic [FREE_IV_W-1:0] r_free_interval;

    // Pulse state.
    logic                  r_last_level, n_last_level;
    logic [WIDTH_BITS-1:0] r_high_count, n_high_count;
    logic                  r_timed_out,  n_timed_out;
    logic [FREE_BITS-1:0]  r_free_count, n_free_count;

    // Output register.
    logic            r_out_valid;
    logic            r_sym_valid, n_sym_valid;
    t_kind           r_kind,      n_kind;
    logic [PW_W-1:0] r_width,     n_width;
    logic            r_bus_free,  n_bus_free;

    logic            in_accept;
    logic [HW-1:0]   width_x;

    // True when a width lies within tol of nom.
    function automatic logic near_width(input logic [HW-1:0] w,
                                        input logic [HW-1:0] nom,
                                        input logic [CFG_W-1:0] tol);
        logic [HW-1:0] d;
        d = (w >= nom) ? (w - nom) : (nom - w);
        return d <= HW'(tol);
    endfunction

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !r_out_valid || o_symbol.ready;
    assign in_accept      = i_sample.valid && i_sample.ready;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_zero_width  <= DEF_BIT_ZERO_WIDTH;
            r_bit_one_width   <= DEF_BIT_ONE_WIDTH;
            r_bit_tolerance   <= DEF_BIT_TOLERANCE;
            r_start_width     <= DEF_START_WIDTH;
            r_start_tolerance <= DEF_START_TOLERANCE;
            r_pulse_timeout   <= DEF_PULSE_TIMEOUT;
            r_free_interval   <= DEF_FREE_INTERVAL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                REG_BIT_ZERO_WIDTH:  r_bit_zero_width  <= i_cfg.data[CFG_W-1:0];
                REG_BIT_ONE_WIDTH:   r_bit_one_width   <= i_cfg.data[CFG_W-1:0];
                REG_BIT_TOLERANCE:   r_bit_tolerance   <= i_cfg.data[CFG_W-1:0];
                REG_START_WIDTH:     r_start_width     <= i_cfg.data[CFG_W-1:0];
                REG_START_TOLERANCE: r_start_tolerance <= i_cfg.data[CFG_W-1:0];
                REG_PULSE_TIMEOUT:   r_pulse_timeout   <= i_cfg.data[CFG_W-1:0];
                REG_FREE_INTERVAL:   r_free_interval   <= i_cfg.data[FREE_IV_W-1:0];
                default: ;
            endcase
        end
    end

    // Next pulse state and the symbol for the sample at the input.
    always_comb begin
        n_last_level = i_sample.bus_level;
        n_high_count = r_high_count;
        n_timed_out  = r_timed_out;
        n_sym_valid  = 1'b0;
        n_kind       = KIND_ZERO;
        width_x      = '0;

        if (i_sample.bus_level) begin
            // High tick: start or extend the pulse, report a timeout once.
            if (!r_last_level) begin
                n_high_count = WIDTH_BITS'(1);
                n_timed_out  = 1'b0;
            end else if (r_high_count != {WIDTH_BITS{1'b1}}) begin
                n_high_count = r_high_count + 1'b1;
            end
            width_x = HW'(n_high_count);
            if (!n_timed_out && (width_x > HW'(r_pulse_timeout))) begin
                n_timed_out = 1'b1;
                n_sym_valid = 1'b1;
                n_kind      = KIND_TIMEOUT;
            end
        end else begin
            // Falling edge of a pulse that did not time out: classify it.
            width_x = HW'(r_high_count);
            if (r_last_level && !r_timed_out) begin
                n_sym_valid = 1'b1;
                if (near_width(width_x, HW'(r_bit_zero_width), r_bit_tolerance)) begin
                    n_kind = KIND_ZERO;
                end else if (near_width(width_x, HW'(r_bit_one_width),
                                        r_bit_tolerance)) begin
                    n_kind = KIND_ONE;
                end else if (near_width(width_x, HW'(r_start_width),
                                        r_start_tolerance)) begin
                    n_kind = KIND_START;
                end else begin
                    n_kind = KIND_BAD;
                end
            end
            n_high_count = '0;
            n_timed_out  = 1'b0;
        end

        // Reported width saturates at the field maximum.
        if (!n_sym_valid) begin
            n_width = '0;
        end else if (width_x > HW'(PW_MAX)) begin
            n_width = PW_MAX;
        end else begin
            n_width = width_x[PW_W-1:0];
        end

        // Free-time counter restarts on a classified falling edge.
        if (n_sym_valid && !i_sample.bus_level) begin
            n_free_count = '0;
        end else if (r_free_count != {FREE_BITS{1'b1}}) begin
            n_free_count = r_free_count + 1'b1;
        end else begin
            n_free_count = r_free_count;
        end

        n_bus_free = !i_sample.bus_level &&
                     (FW'(n_free_count) >= FW'(r_free_interval));
    end

    // Pulse state registers, updated on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_high_count <= '0;
            r_timed_out  <= 1'b0;
            r_free_count <= '0;
        end else if (in_accept) begin
            r_last_level <= n_last_level;
            r_high_count <= n_high_count;
            r_timed_out  <= n_timed_out;
            r_free_count <= n_free_count;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_symbol.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sym_valid <= n_sym_valid;
            r_kind      <= n_kind;
            r_width     <= n_width;
            r_bus_free  <= n_bus_free;
        end
    end

    assign o_symbol.valid        = r_out_valid;
    assign o_symbol.symbol_valid = r_sym_valid;
    assign o_symbol.symbol_kind  = r_kind;
    assign o_symbol.pulse_width  = r_width;
    assign o_symbol.bus_free     = r_bus_free;

    // A pulse is in progress exactly when the last sample was high.
    a_count_tracks_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_high_count == '0) == !r_last_level)
        else $error("high count disagrees with last level");

    // A timeout can only be pending inside a pulse.
    a_timeout_in_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timed_out |-> r_last_level)
        else $error("timeout flag set while line low");

    // A rising edge starts the count at one.
    a_rise_starts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_sample.bus_level && !r_last_level) |=> (r_high_count == 1))
        else $error("rising edge did not restart the count");

    // A result without a symbol carries zero kind and width.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_sym_valid) |-> (r_kind == KIND_ZERO && r_width == '0))
        else $error("empty result carries a symbol payload");

endmodule

// ===== rtl/core/iebus_pulse_symbol_receiver_core.sv =====
// Channel     Dir  Payload                                          Accept
// i_sample    in   bus_level                                        valid & ready
// o_symbol    out  symbol_valid, symbol_kind, pulse_width, bus_free valid & ready
// i_cfg       in   index (3 bits), data (16 bits)                   valid & ready
//
// One result per line sample, in the cycle after the sample is accepted; a new
// sample is taken every cycle while results are drained. The result is held in
// the single output register of iepsr_core. Synchronous active-low reset loads
// the register defaults and clears the pulse and free-time counters. With the
// result register full and o_symbol.ready low, i_sample.ready drops.
// Depends on iepsr_pkg, iepsr_ifs and iepsr_core.
module iebus_pulse_symbol_receiver_core #(
    parameter int WIDTH_BITS = iepsr_pkg::WIDTH_BITS_DEF,
    parameter int FREE_BITS  = iepsr_pkg::FREE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    iepsr_sample_if.sink    i_sample,
    iepsr_symbol_if.source  o_symbol,
    iepsr_cfg_if.sink       i_cfg
);
    import iepsr_pkg::*;

    // Symbol decoder with its configuration and output register.
    iepsr_core #(
        .WIDTH_BITS (WIDTH_BITS),
        .FREE_BITS  (FREE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .o_symbol (o_symbol),
        .i_cfg    (i_cfg)
    );

endmodule
